@@ hw/rtl/gha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Operation and status codes, fixed field widths and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package gha_pkg;

	// fixed port field widths
	localparam int OP_W     = 2;
	localparam int ID_FW    = 10;
	localparam int GEN_FW   = 16;
	localparam int STATUS_W = 2;

	// operation codes
	localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
	localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
	localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// controller -> datapath commands
	typedef struct packed {
		logic capture;  // latch the incoming item
		logic pop_rd;   // read the top of the free stack
		logic tbl_rd;   // read the generation table
		logic commit;   // write state back and load the result register
	} gha_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic in_pop;   // incoming item is a create served from the free stack
		logic out_free; // result register can take a new item this cycle
	} gha_stat_t;

endpackage : gha_pkg
`default_nettype wire

@@ hw/rtl/generational_handle_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted item is captured; a create that recycles an id from the
// free stack reads the stack; then the table is read and the result committed.
// The input is stalled from accept until commit, so only one item is in flight
// at a time; a held result delays the commit.
// Reset: counters, controller and result valid clear at once; memories are
// not cleared and need no clearing pass, contents are used only where written.
// ----------------------------------------------------------------------------
// Generational handle allocator
// Hands out id/generation handles from a free stack or fresh ids, destroys
// and checks handles against a per-id generation and alive table.
// ----------------------------------------------------------------------------
module generational_handle_allocator #(
	parameter int MAX_ENTITIES = 1024,
	parameter int GEN_WIDTH    = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [gha_pkg::OP_W-1:0]      operation,
	input  wire logic [gha_pkg::ID_FW-1:0]     entity_id,
	input  wire logic [gha_pkg::GEN_FW-1:0]    entity_generation,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [gha_pkg::ID_FW-1:0]          handle_id,
	output logic [gha_pkg::GEN_FW-1:0]         handle_generation,
	output logic                               alive,
	output logic [gha_pkg::STATUS_W-1:0]       status
);
	import gha_pkg::*;

	gha_cmd_t  cmd;
	gha_stat_t stat;

	gha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	gha_dp #(
		.MAX_ENTITIES (MAX_ENTITIES),
		.GEN_WIDTH    (GEN_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.operation         (operation),
		.entity_id         (entity_id),
		.entity_generation (entity_generation),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.handle_id         (handle_id),
		.handle_generation (handle_generation),
		.alive             (alive),
		.status            (status)
	);

endmodule : generational_handle_allocator
`default_nettype wire

@@ hw/rtl/gha_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences one item through a free stack read (recycling creates only), table read and commit.
// ----------------------------------------------------------------------------
module gha_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire gha_pkg::gha_stat_t stat,
	output gha_pkg::gha_cmd_t       cmd
);
	import gha_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_TRD  = 2'd2;
	localparam logic [1:0] S_EXE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = stat.in_pop ? S_POP : S_TRD;
				end
			end
			S_POP: begin
				cmd.pop_rd = 1'b1;
				state_d    = S_TRD;
			end
			S_TRD: begin
				cmd.tbl_rd = 1'b1;
				state_d    = S_EXE;
			end
			S_EXE: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule : gha_ctrl
`default_nettype wire

@@ hw/rtl/gha_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator datapath
// Free stack memory, generation/alive table memory, counters, handle check
// and the result register.
// ----------------------------------------------------------------------------
module gha_dp #(
	parameter int MAX_ENTITIES = 1024,
	parameter int GEN_WIDTH    = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire gha_pkg::gha_cmd_t             cmd,
	output gha_pkg::gha_stat_t                 stat,
	input  wire logic [gha_pkg::OP_W-1:0]      operation,
	input  wire logic [gha_pkg::ID_FW-1:0]     entity_id,
	input  wire logic [gha_pkg::GEN_FW-1:0]    entity_generation,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [gha_pkg::ID_FW-1:0]          handle_id,
	output logic [gha_pkg::GEN_FW-1:0]         handle_generation,
	output logic                               alive,
	output logic [gha_pkg::STATUS_W-1:0]       status
);
	import gha_pkg::*;

	localparam int ID_W  = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
	localparam int ID_E  = (ID_W > ID_FW) ? ID_W : ID_FW;
	localparam int CMP_W = (CNT_W > ID_FW) ? CNT_W : ID_FW;
	localparam int GEN_E = (GEN_WIDTH > GEN_FW) ? GEN_WIDTH : GEN_FW;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTITIES);

	// memories: free stack of ids, table of {alive, generation}
	logic [ID_W-1:0]      stack_mem [MAX_ENTITIES];
	logic [GEN_WIDTH:0]   tbl_mem   [MAX_ENTITIES];

	// counters
	logic [CNT_W-1:0] free_cnt_q;
	logic [CNT_W-1:0] used_cnt_q;

	// captured item
	logic [OP_W-1:0]   op_q;
	logic [ID_FW-1:0]  id_q;
	logic [GEN_FW-1:0] gen_q;
	logic              pop_q;

	// registered memory reads
	logic [ID_W-1:0]    stack_rd_q;
	logic [GEN_WIDTH:0] tbl_rd_q;

	// result register
	logic                out_valid_q;
	logic [ID_FW-1:0]    res_id_q;
	logic [GEN_FW-1:0]   res_gen_q;
	logic                res_alive_q;
	logic [STATUS_W-1:0] res_status_q;

	// commit-time signals
	logic [CNT_W-1:0]     free_dec;
	logic [ID_E-1:0]      id_ext;
	logic [ID_W-1:0]      id_addr;
	logic [GEN_WIDTH-1:0] tbl_gen;
	logic                 tbl_alive;
	logic                 id_in_use;
	logic                 gen_match;
	logic                 handle_ok;
	logic [ID_W-1:0]      nid;
	logic [GEN_WIDTH-1:0] ngen;
	logic [ID_E-1:0]      nid_ext;
	logic [GEN_E-1:0]     ngen_ext;
	logic                 wr_en;
	logic [ID_W-1:0]      wr_addr;
	logic [GEN_WIDTH:0]   wr_data;
	logic                 do_push;
	logic                 do_pop;
	logic                 do_fresh;
	logic [ID_FW-1:0]     res_id;
	logic [GEN_FW-1:0]    res_gen;
	logic                 res_alive;
	logic [STATUS_W-1:0]  res_status;

	assign free_dec  = free_cnt_q - CNT_W'(1);
	assign id_ext    = ID_E'(id_q);
	assign id_addr   = id_ext[ID_W-1:0];
	assign tbl_gen   = tbl_rd_q[GEN_WIDTH-1:0];
	assign tbl_alive = tbl_rd_q[GEN_WIDTH];
	assign id_in_use = CMP_W'(id_q) < CMP_W'(used_cnt_q);
	assign gen_match = GEN_E'(gen_q) == GEN_E'(tbl_gen);
	assign handle_ok = id_in_use && tbl_alive && gen_match;

	// create picks a recycled id or the next fresh one
	assign nid      = pop_q ? stack_rd_q : used_cnt_q[ID_W-1:0];
	assign ngen     = pop_q ? tbl_gen : '0;
	assign nid_ext  = ID_E'(nid);
	assign ngen_ext = GEN_E'(ngen);

	// status toward the controller
	assign stat.in_pop   = (operation == OP_CREATE) && (free_cnt_q != '0);
	assign stat.out_free = !out_valid_q || !out_stall;

	// operation decode at commit
	always_comb begin
		res_id     = id_q;
		res_gen    = gen_q;
		res_alive  = 1'b0;
		res_status = ST_BAD;
		wr_en      = 1'b0;
		wr_addr    = id_addr;
		wr_data    = {1'b0, tbl_gen + GEN_WIDTH'(1)};
		do_push    = 1'b0;
		do_pop     = 1'b0;
		do_fresh   = 1'b0;
		case (op_q)
			OP_CREATE: begin
				if (pop_q || (used_cnt_q < MAX_CNT)) begin
					do_pop     = pop_q;
					do_fresh   = !pop_q;
					wr_en      = 1'b1;
					wr_addr    = nid;
					wr_data    = {1'b1, ngen};
					res_id     = nid_ext[ID_FW-1:0];
					res_gen    = ngen_ext[GEN_FW-1:0];
					res_alive  = 1'b1;
					res_status = ST_OK;
				end else begin
					res_status = ST_FULL;
				end
			end
			OP_DESTROY: begin
				if (handle_ok) begin
					wr_en      = 1'b1;
					do_push    = (free_cnt_q < MAX_CNT);
					res_status = ST_OK;
				end
			end
			OP_CHECK: begin
				if (handle_ok) begin
					res_alive  = 1'b1;
					res_status = ST_OK;
				end
			end
			default: begin
				res_status = ST_BAD;
			end
		endcase
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			id_q  <= entity_id;
			gen_q <= entity_generation;
			pop_q <= stat.in_pop;
		end
	end

	// free stack port
	always_ff @(posedge clk) begin
		if (cmd.pop_rd) begin
			stack_rd_q <= stack_mem[free_dec[ID_W-1:0]];
		end
		if (cmd.commit && do_push) begin
			stack_mem[free_cnt_q[ID_W-1:0]] <= id_addr;
		end
	end

	// generation table port
	always_ff @(posedge clk) begin
		if (cmd.tbl_rd) begin
			tbl_rd_q <= tbl_mem[pop_q ? stack_rd_q : id_addr];
		end
		if (cmd.commit && wr_en) begin
			tbl_mem[wr_addr] <= wr_data;
		end
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_cnt_q <= '0;
			used_cnt_q <= '0;
		end else if (cmd.commit) begin
			if (do_pop) begin
				free_cnt_q <= free_dec;
			end else if (do_push) begin
				free_cnt_q <= free_cnt_q + CNT_W'(1);
			end
			if (do_fresh) begin
				used_cnt_q <= used_cnt_q + CNT_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_id_q     <= res_id;
			res_gen_q    <= res_gen;
			res_alive_q  <= res_alive;
			res_status_q <= res_status;
		end
	end

	assign out_valid         = out_valid_q;
	assign handle_id         = res_id_q;
	assign handle_generation = res_gen_q;
	assign alive             = res_alive_q;
	assign status            = res_status_q;

endmodule : gha_dp
`default_nettype wire

@@ hw/rtl/gha_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module gha_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic [gha_pkg::OP_W-1:0]      operation,
	input wire logic [gha_pkg::ID_FW-1:0]     entity_id,
	input wire logic [gha_pkg::GEN_FW-1:0]    entity_generation,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [gha_pkg::ID_FW-1:0]     handle_id,
	input wire logic [gha_pkg::GEN_FW-1:0]    handle_generation,
	input wire logic                          alive,
	input wire logic [gha_pkg::STATUS_W-1:0]  status
);
	import gha_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(handle_id) && $stable(handle_generation)
			&& $stable(alive) && $stable(status))
		else $error("stalled result changed");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in flight");

	// a live handle only comes with ok status
	a_alive_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alive |-> status == ST_OK)
		else $error("alive result with error status");

endmodule : gha_checker

bind generational_handle_allocator gha_checker u_gha_checker (.*);
`default_nettype wire
